>>> rtl/strs_pkg.sv
`default_nettype none

package strs_pkg;

	// Widths fixed by the field definitions
	localparam int ValueW  = 32;
	localparam int TimeW   = 32;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 32;

	// Item command codes
	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_REPORT_MIN = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_REPORT_MAX = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ON_CHANGE  = 2'd2;

	// Min/max code bit positions
	localparam int CodeMinBit = 0;
	localparam int CodeMaxBit = 1;

	typedef struct packed {
		logic                     command;
		logic signed [ValueW-1:0] sample_value;
		logic                     sample_valid;
	} item_t;

	typedef struct packed {
		logic                     value_changed;
		logic [1:0]               min_max_code;
		logic                     report_due;
		logic signed [ValueW-1:0] current_value;
		logic                     current_valid;
		logic signed [ValueW-1:0] min_value;
		logic signed [ValueW-1:0] max_value;
		logic                     min_max_valid;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/sample_tracker_report_scheduler.sv
// Sample tracker and report scheduler. Each input beat is either a sample
// (stores a signed Q16.16 value or marks it as not a number, flags a change and
// updates the running min/max) or a one-millisecond tick (advances a wrapping
// 32-bit ms clock and, while report_min_ms is nonzero, raises report_due by the
// on-change or the pure-time rule; a report clears the pending change and
// restarts the interval). Every input beat gives exactly one result beat.
// The input register feeds the compare/update logic that loads the result
// register, so each accepted beat passes the input register and then the
// result register before it can be taken.
// One beat per cycle is sustained; the only thing that stalls input is a full
// result register that the consumer is not taking. Configuration writes take
// effect on the next cycle and must only be issued while no beat is in flight.
`default_nettype none

module sample_tracker_report_scheduler (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_write,
	input  wire logic [strs_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [strs_pkg::CfgW-1:0]         cfg_data,
	// input items
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire strs_pkg::item_t                   item,
	// results
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output strs_pkg::result_t                      result
);

	// Configuration registers
	logic [strs_pkg::TimeW-1:0] report_min_q;
	logic [strs_pkg::TimeW-1:0] report_max_q;
	logic                       on_change_q;

	// Tracker state. The time of the last sample is not kept: nothing
	// observable depends on it.
	logic [strs_pkg::TimeW-1:0]          clock_q;
	logic [strs_pkg::TimeW-1:0]          start_q;
	logic signed [strs_pkg::ValueW-1:0]  value_q;
	logic                                valid_q;
	logic                                pending_q;
	logic signed [strs_pkg::ValueW-1:0]  min_q;
	logic signed [strs_pkg::ValueW-1:0]  max_q;
	logic                                ext_valid_q;

	// Input stage
	logic            valid_s1;
	strs_pkg::item_t item_s1;

	// Result register
	logic              res_valid_q;
	strs_pkg::result_t res_q;

	logic advance;

	// Next-state values
	logic                                same;
	logic signed [strs_pkg::ValueW-1:0]  nxt_value;
	logic                                nxt_valid;
	logic                                nxt_pending;
	logic signed [strs_pkg::ValueW-1:0]  nxt_min;
	logic signed [strs_pkg::ValueW-1:0]  nxt_max;
	logic                                nxt_ext;
	logic                                new_min;
	logic                                new_max;
	logic [strs_pkg::TimeW-1:0]          nxt_clock;
	logic [strs_pkg::TimeW-1:0]          nxt_start;
	logic [strs_pkg::TimeW-1:0]          elapsed;
	logic                                due;
	logic                                changed;
	strs_pkg::result_t                   res_d;

	// The stage moves when the result register is empty or being drained.
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		same        = 1'b0;
		changed     = 1'b0;
		nxt_value   = value_q;
		nxt_valid   = valid_q;
		nxt_pending = pending_q;
		nxt_min     = min_q;
		nxt_max     = max_q;
		nxt_ext     = ext_valid_q;
		new_min     = 1'b0;
		new_max     = 1'b0;
		nxt_clock   = clock_q;
		nxt_start   = start_q;
		elapsed     = '0;
		due         = 1'b0;

		unique case (strs_pkg::cmd_t'(item_s1.command))
			strs_pkg::CMD_SAMPLE: begin
				// Equal only when both sides are numbers and bits match;
				// a NaN sample always counts as a change.
				same = item_s1.sample_valid && valid_q &&
					(item_s1.sample_value == value_q);
				if (!same) begin
					changed     = 1'b1;
					nxt_value   = item_s1.sample_valid ? item_s1.sample_value : '0;
					nxt_valid   = item_s1.sample_valid;
					nxt_pending = 1'b1;
				end
				// Extremes follow the stored value whenever it is a number.
				if (nxt_valid) begin
					new_max = !ext_valid_q || (max_q < nxt_value);
					new_min = !ext_valid_q || (nxt_value < min_q);
					if (new_max) begin
						nxt_max = nxt_value;
					end
					if (new_min) begin
						nxt_min = nxt_value;
					end
					nxt_ext = 1'b1;
				end
			end
			strs_pkg::CMD_TICK: begin
				nxt_clock = clock_q + 32'd1;
				elapsed   = nxt_clock - start_q;   // wraps mod 2^32
				if (report_min_q != '0) begin
					if (on_change_q) begin
						due = (pending_q && (elapsed > report_min_q)) ||
							(elapsed > report_max_q);
					end else begin
						due = elapsed > report_min_q;
					end
				end
				if (due) begin
					nxt_pending = 1'b0;
					nxt_start   = nxt_clock;
				end
			end
			default: ;
		endcase

		res_d                                   = '0;
		res_d.value_changed                     = changed;
		res_d.min_max_code[strs_pkg::CodeMinBit] = new_min;
		res_d.min_max_code[strs_pkg::CodeMaxBit] = new_max;
		res_d.report_due                        = due;
		// a NaN stored value is held as zero, so it reads as zero here
		res_d.current_value                     = nxt_value;
		res_d.current_valid                     = nxt_valid;
		res_d.min_value                         = nxt_min;
		res_d.max_value                         = nxt_max;
		res_d.min_max_valid                     = nxt_ext;
	end

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_min_q <= '0;
			report_max_q <= '0;
			on_change_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				strs_pkg::CFG_REPORT_MIN: report_min_q <= cfg_data;
				strs_pkg::CFG_REPORT_MAX: report_max_q <= cfg_data;
				strs_pkg::CFG_ON_CHANGE:  on_change_q  <= cfg_data[0];
				default: ;   // unmapped index, ignored
			endcase
		end
	end

	// Control and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			clock_q     <= '0;
			start_q     <= '0;
			value_q     <= '0;
			valid_q     <= 1'b0;
			pending_q   <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
			ext_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance) begin
				clock_q     <= nxt_clock;
				start_q     <= nxt_start;
				value_q     <= nxt_value;
				valid_q     <= nxt_valid;
				pending_q   <= nxt_pending;
				min_q       <= nxt_min;
				max_q       <= nxt_max;
				ext_valid_q <= nxt_ext;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/strs_checker.sv
`default_nettype none

module strs_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         result_valid,
	input wire logic                         result_ready,
	input wire strs_pkg::result_t            result
);

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// a new min or max only appears once extremes exist
	a_code_has_ext: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.min_max_code != 2'd0) |-> result.min_max_valid)
		else $error("min/max code without valid extremes");

	// running extremes stay ordered
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.min_max_valid |->
			!($signed(result.max_value) < $signed(result.min_value)))
		else $error("running max below running min");

	// a report comes only from a tick, which never flags a value change
	a_due_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.report_due |->
			!result.value_changed && (result.min_max_code == 2'd0))
		else $error("report due on a sample beat");

endmodule

bind sample_tracker_report_scheduler strs_checker u_strs_checker (.*);

`default_nettype wire

>>> bench/tb_sample_tracker_report_scheduler.sv
`timescale 1ns / 100ps

module tb_sample_tracker_report_scheduler;

	// index past the end of the register list; the block must ignore it
	localparam logic [strs_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

	// ---------------------------------------------------------------
	// DUT signals; every bench-driven one is known from time zero
	// ---------------------------------------------------------------
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_write = 1'b0;
	logic [strs_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [strs_pkg::CfgW-1:0]    cfg_data = '0;
	logic                         item_valid = 1'b0;
	logic                         item_ready;
	strs_pkg::item_t              item_bus = '0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	strs_pkg::result_t            result_bus;

	sample_tracker_report_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus)
	);

	// ---------------------------------------------------------------
	// Tracker state mirrored by the bench
	// ---------------------------------------------------------------
	logic [strs_pkg::TimeW-1:0]         min_interval_ms;
	logic [strs_pkg::TimeW-1:0]         max_interval_ms;
	logic                               change_mode;
	logic [strs_pkg::TimeW-1:0]         ms_clock;
	logic [strs_pkg::TimeW-1:0]         interval_start;
	logic [strs_pkg::TimeW-1:0]         last_sample_at;
	logic signed [strs_pkg::ValueW-1:0] held_value;
	logic                               held_valid;
	logic                               change_pending;
	logic signed [strs_pkg::ValueW-1:0] lowest;
	logic signed [strs_pkg::ValueW-1:0] highest;
	logic                               extremes_seen;

	// results owed by the block, oldest first
	strs_pkg::result_t owed_results[$];

	// bookkeeping
	int  mismatches = 0;
	int  beats_in = 0;
	int  beats_out = 0;
	int  n_samples = 0;
	int  n_ticks = 0;
	int  n_reports = 0;
	int  n_changes = 0;
	int  n_new_min = 0;
	int  n_new_max = 0;
	bit  steady = 1'b0;   // no idling on either side while set

	// ---------------------------------------------------------------
	// Clock and watchdog
	// ---------------------------------------------------------------
	initial begin
		forever #4 clk = ~clk;
	end

	// bounds the run; if the sequence never finishes, it reports errors
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor: one call per accepted input beat
	// ---------------------------------------------------------------
	function automatic strs_pkg::result_t track_step(strs_pkg::item_t it);
		strs_pkg::result_t          r;
		logic                       same;
		logic                       due;
		logic [strs_pkg::TimeW-1:0] elapsed;
		r = '0;
		if (it.command == strs_pkg::CMD_SAMPLE) begin
			// invalid samples never compare equal, even to another invalid one
			same = it.sample_valid && held_valid && (it.sample_value == held_value);
			if (!same) begin
				r.value_changed = 1'b1;
				held_value = it.sample_valid ? it.sample_value : '0;
				held_valid = it.sample_valid;
				change_pending = 1'b1;
				last_sample_at = ms_clock;
			end
			// extremes follow the held value, only while it is a number
			if (held_valid) begin
				if (!extremes_seen || highest < held_value) begin
					highest = held_value;
					r.min_max_code[strs_pkg::CodeMaxBit] = 1'b1;
				end
				if (!extremes_seen || held_value < lowest) begin
					lowest = held_value;
					r.min_max_code[strs_pkg::CodeMinBit] = 1'b1;
				end
				extremes_seen = 1'b1;
			end
		end else begin
			ms_clock = ms_clock + 32'd1;
			if (min_interval_ms != '0) begin
				elapsed = ms_clock - interval_start;
				if (change_mode)
					due = (change_pending && elapsed > min_interval_ms) ||
						(elapsed > max_interval_ms);
				else
					due = elapsed > min_interval_ms;
				if (due) begin
					r.report_due = 1'b1;
					change_pending = 1'b0;
					interval_start = ms_clock;
				end
			end
		end
		r.current_value = held_valid ? held_value : '0;
		r.current_valid = held_valid;
		r.min_value = lowest;
		r.max_value = highest;
		r.min_max_valid = extremes_seen;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result side: random backpressure and the checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 19);
	end

	task automatic flag_error(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] result beat %0d: %s expected %h got %h",
				$realtime, beats_out, what, want, got);
	endtask

	task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			flag_error(what, want, got);
	endtask

	always @(posedge clk) begin : result_checker
		strs_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			beats_out++;
			if (owed_results.size() == 0) begin
				flag_error("unexpected beat, nothing owed", '0, result_bus.current_value);
			end else begin
				want = owed_results.pop_front();
				compare_field("value_changed", 32'(want.value_changed),
					32'(result_bus.value_changed));
				compare_field("min_max_code", 32'(want.min_max_code),
					32'(result_bus.min_max_code));
				compare_field("report_due", 32'(want.report_due),
					32'(result_bus.report_due));
				compare_field("current_value", want.current_value, result_bus.current_value);
				compare_field("current_valid", 32'(want.current_valid),
					32'(result_bus.current_valid));
				compare_field("min_value", want.min_value, result_bus.min_value);
				compare_field("max_value", want.max_value, result_bus.max_value);
				compare_field("min_max_valid", 32'(want.min_max_valid),
					32'(result_bus.min_max_valid));
			end
		end
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------
	// Sends one beat and records what it should produce. Valid is left high
	// on return so back-to-back beats never drop it; gaps lower it first.
	task automatic send_item(strs_pkg::item_t it);
		strs_pkg::result_t r;
		if (!steady && $urandom_range(99) < 19) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_bus <= it;
		do @(posedge clk); while (!item_ready);
		beats_in++;
		r = track_step(it);
		owed_results.push_back(r);
		if (it.command == strs_pkg::CMD_SAMPLE)
			n_samples++;
		else
			n_ticks++;
		n_reports += int'(r.report_due);
		n_changes += int'(r.value_changed);
		n_new_min += int'(r.min_max_code[strs_pkg::CodeMinBit]);
		n_new_max += int'(r.min_max_code[strs_pkg::CodeMaxBit]);
	endtask

	task automatic send_sample(logic signed [strs_pkg::ValueW-1:0] v, logic ok);
		strs_pkg::item_t it;
		it.command = strs_pkg::CMD_SAMPLE;
		it.sample_value = v;
		it.sample_valid = ok;
		send_item(it);
	endtask

	// payload fields other than the command are don't-care for a tick
	task automatic send_ticks(int count);
		strs_pkg::item_t it;
		repeat (count) begin
			it.command = strs_pkg::CMD_TICK;
			it.sample_value = $urandom;
			it.sample_valid = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	// Stop sending and let every owed result drain before going on.
	task automatic settle();
		item_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers are only touched with the pipeline empty.
	task automatic program_regs(logic [strs_pkg::TimeW-1:0] lo_ms,
		logic [strs_pkg::TimeW-1:0] hi_ms, logic on_change, bit poke_spare);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= strs_pkg::CFG_REPORT_MIN;
		cfg_data <= lo_ms;
		@(posedge clk);
		cfg_index <= strs_pkg::CFG_REPORT_MAX;
		cfg_data <= hi_ms;
		@(posedge clk);
		// only bit 0 matters; junk above it must be dropped
		cfg_index <= strs_pkg::CFG_ON_CHANGE;
		cfg_data <= {(strs_pkg::CfgW-1)'($urandom), on_change};
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data <= '1;
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		min_interval_ms = lo_ms;
		max_interval_ms = hi_ms;
		change_mode = on_change;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Not subscribed: ticks never report. Walks the sample special cases:
	// invalid with junk bits, invalid twice, first valid value, repeat,
	// both value extremes, and a value inside the current range.
	task automatic test_unsubscribed_samples();
		program_regs('0, '0, 1'b0, 1'b1);
		send_ticks(1);
		send_sample(32'sh0001_2345, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b1);
		send_sample('0, 1'b1);
		send_sample(32'sh7FFF_FFFF, 1'b1);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(-32'sd1, 1'b1);
		send_ticks(1);
	endtask

	// Pure time rule: report every min+1 ms, interval restarts on report.
	task automatic test_time_rule();
		program_regs(32'd2, '0, 1'b0, 1'b0);
		send_ticks(4);
	endtask

	// On-change rule: a change reports once past the minimum, then with no
	// change the maximum forces one.
	task automatic test_change_rule();
		program_regs(32'd3, 32'd6, 1'b1, 1'b0);
		send_sample(32'sh0001_8000, 1'b1);
		send_ticks(11);
	endtask

	// Random traffic: runs of samples and runs of ticks, so changes line up
	// with interval boundaries. Samples often come from a small pool to get
	// repeats and equal values, with extremes and full random values mixed in.
	task automatic test_random_phase(int count, bit no_idle, bit pause_midway);
		logic signed [strs_pkg::ValueW-1:0] pool[4];
		logic signed [strs_pkg::ValueW-1:0] v;
		int sent;
		int run_len;
		int pick;
		bit is_sample;
		bit paused;
		pool[0] = $urandom;
		pool[1] = $urandom;
		pool[2] = $signed($urandom_range(255) << 16);
		pool[3] = -$signed($urandom_range(255) << 16);
		steady = no_idle;
		sent = 0;
		paused = 1'b0;
		while (sent < count) begin
			if (pause_midway && !paused && sent >= count / 2) begin
				settle();
				paused = 1'b1;
			end
			is_sample = $urandom_range(99) < 45;
			run_len = is_sample ? $urandom_range(1, 4) : $urandom_range(1, 12);
			repeat (run_len) begin
				if (is_sample) begin
					pick = $urandom_range(99);
					if (pick < 40)
						v = pool[2'($urandom_range(3))];
					else if (pick < 55)
						case ($urandom_range(3))
							0: v = 32'sh7FFF_FFFF;
							1: v = 32'sh8000_0000;
							2: v = '0;
							default: v = -32'sd1;
						endcase
					else
						v = $urandom;
					send_sample(v, $urandom_range(99) >= 15);
				end else begin
					send_ticks(1);
				end
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin : main
		int waited;
		// bench copy of the reset state
		min_interval_ms = '0;
		max_interval_ms = '0;
		change_mode = 1'b0;
		ms_clock = '0;
		interval_start = '0;
		last_sample_at = '0;
		held_value = '0;
		held_valid = 1'b0;
		change_pending = 1'b0;
		lowest = '0;
		highest = '0;
		extremes_seen = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsubscribed_samples();
		test_time_rule();
		test_change_rule();

		// every tick reports when the maximum is zero
		program_regs(32'd1, '0, 1'b1, 1'b0);
		test_random_phase(104, 1'b0, 1'b0);
		program_regs($urandom_range(1, 6), $urandom_range(0, 12), 1'b1, 1'b0);
		test_random_phase(104, 1'b0, 1'b0);
		// stretch with both sides always ready
		program_regs($urandom_range(1, 6), $urandom_range(0, 12), 1'b0, 1'b0);
		test_random_phase(104, 1'b1, 1'b0);
		// largest intervals: nothing can come due
		program_regs('1, '1, 1'b1, 1'b0);
		test_random_phase(104, 1'b0, 1'b0);
		program_regs($urandom_range(2, 8), $urandom_range(4, 16), 1'b1, 1'b0);
		test_random_phase(104, 1'b0, 1'b1);
		// full-width register values
		program_regs($urandom, $urandom, 1'($urandom_range(1)), 1'b1);
		test_random_phase(104, 1'b0, 1'b0);
		program_regs('0, $urandom_range(0, 5), 1'b1, 1'b0);
		test_random_phase(104, 1'b0, 1'b0);

		// drain, bounded, then allow for the input and result registers
		item_valid <= 1'b0;
		waited = 0;
		while (owed_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		$display("covered %0d beats in / %0d out: %0d samples, %0d ticks, %0d reports",
			beats_in, beats_out, n_samples, n_ticks, n_reports);
		$display("  %0d value changes, %0d new minimums, %0d new maximums, %0d mismatches",
			n_changes, n_new_min, n_new_max, mismatches);
		if (owed_results.size() != 0)
			$display("%0d results never arrived", owed_results.size());
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/strs_pkg.sv
rtl/sample_tracker_report_scheduler.sv
rtl/strs_checker.sv
bench/tb_sample_tracker_report_scheduler.sv
